// ----- design/pfsm_pkg.sv -----
package pfsm_pkg;

	// Field widths
	localparam int W_CMD   = 2;
	localparam int W_FLEN  = 40;
	localparam int W_PNUM  = 20;
	localparam int W_BYTES = 27;
	localparam int W_STAT  = 2;
	localparam int W_IDX   = 4;
	localparam int W_START = 41;
	localparam int W_END   = 42;               // start + length
	localparam int W_POFF  = 48;               // piece offset plus remaining bytes
	localparam int W_PROD  = W_PNUM + W_BYTES; // piece_number * piece_size

	localparam logic [W_BYTES-1:0] PIECE_SIZE_RST = W_BYTES'(262144);

	// Command codes
	localparam logic [W_CMD-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [W_CMD-1:0] CMD_APPEND = 2'd1;
	localparam logic [W_CMD-1:0] CMD_MAP    = 2'd2;

	// Status codes
	localparam logic [W_STAT-1:0] ST_SEGMENT = 2'd0;
	localparam logic [W_STAT-1:0] ST_NO_OVL  = 2'd1;
	localparam logic [W_STAT-1:0] ST_APP_OK  = 2'd2;
	localparam logic [W_STAT-1:0] ST_FULL    = 2'd3;

	// Microcode
	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,   // take input transaction
		OP_MUL,      // piece offset = piece_number * piece_size, reset walk
		OP_RD,       // issue table read at walk index
		OP_LD,       // latch entry, form file end and range end
		OP_CHK,      // overlap test, start in file, raw end
		OP_CALC,     // segment width
		OP_EMIT,     // flush held segment, hold the new one, advance
		OP_NEXT,     // walk index + 1
		OP_MFIN,     // final map result
		OP_CMD       // clear / append / ignore
	} op_t;

	typedef enum logic [2:0] {
		H_NONE,
		H_IN,        // no input valid
		H_HELD,      // held segment cannot be flushed
		H_OUT,       // output register busy
		H_APPEND     // append result cannot be loaded
	} hold_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_MAP,
		C_WALK_DONE,
		C_NO_OVL
	} cond_t;

	typedef struct packed {
		op_t             op;
		hold_t           hold;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	localparam logic [PC_W-1:0] PC_ACCEPT = 4'd0;
	localparam logic [PC_W-1:0] PC_DISP   = 4'd1;
	localparam logic [PC_W-1:0] PC_MUL    = 4'd2;
	localparam logic [PC_W-1:0] PC_RD     = 4'd3;
	localparam logic [PC_W-1:0] PC_LD     = 4'd4;
	localparam logic [PC_W-1:0] PC_CHK    = 4'd5;
	localparam logic [PC_W-1:0] PC_CALC   = 4'd6;
	localparam logic [PC_W-1:0] PC_EMIT   = 4'd7;
	localparam logic [PC_W-1:0] PC_NEXT   = 4'd8;
	localparam logic [PC_W-1:0] PC_MFIN   = 4'd9;
	localparam logic [PC_W-1:0] PC_CMD    = 4'd10;

	// Control store: jump taken -> target, else pc + 1; hold keeps the step.
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t c;
		case (pc)
			PC_ACCEPT: c = '{OP_ACCEPT, H_IN,     C_NEVER,     PC_ACCEPT};
			PC_DISP:   c = '{OP_NOP,    H_NONE,   C_NOT_MAP,   PC_CMD};
			PC_MUL:    c = '{OP_MUL,    H_NONE,   C_NEVER,     PC_ACCEPT};
			PC_RD:     c = '{OP_RD,     H_NONE,   C_WALK_DONE, PC_MFIN};
			PC_LD:     c = '{OP_LD,     H_NONE,   C_NEVER,     PC_ACCEPT};
			PC_CHK:    c = '{OP_CHK,    H_NONE,   C_NEVER,     PC_ACCEPT};
			PC_CALC:   c = '{OP_CALC,   H_NONE,   C_NO_OVL,    PC_NEXT};
			PC_EMIT:   c = '{OP_EMIT,   H_HELD,   C_NEVER,     PC_ACCEPT};
			PC_NEXT:   c = '{OP_NEXT,   H_NONE,   C_ALWAYS,    PC_RD};
			PC_MFIN:   c = '{OP_MFIN,   H_OUT,    C_ALWAYS,    PC_ACCEPT};
			PC_CMD:    c = '{OP_CMD,    H_APPEND, C_ALWAYS,    PC_ACCEPT};
			default:   c = '{OP_NOP,    H_NONE,   C_ALWAYS,    PC_ACCEPT};
		endcase
		return c;
	endfunction

endpackage

// ----- design/pfsm_ram.sv -----
module pfsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/piece_to_file_segment_mapper_top.sv -----
// Piece-to-file segment mapper. Keeps an ordered table of up to MAX_FILES file
// lengths with their start offsets in the concatenated byte space, and serves
// three commands: clear (empties the table, no result), append (one result:
// append ok with the new entry index, or table full) and map (one result per
// file that the piece's byte range overlaps, the final one flagged by last, or
// a single no-overlap result). Unused command codes are dropped silently.
// piece_size is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block does not enforce. It resets to
// 262144. Both channels move one transaction per edge with valid high and stall
// low. Control is a small microcode store stepped by a program counter; one
// input transaction is taken at a time. A map walks the table entries and stops
// once all bytes are placed or every entry is walked: each entry needs a table
// read through the single registered read port of the table RAM, then latch,
// overlap test and width steps; emitting a segment adds one step. Emitting and
// the final result wait while the output register is full and stalled. The start
// offset saturates at 2^41-1.
module piece_to_file_segment_mapper_top #(
	parameter int MAX_FILES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [pfsm_pkg::W_BYTES-1:0]  cfg_wr_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pfsm_pkg::W_CMD-1:0]    cmd,
	input  logic [pfsm_pkg::W_FLEN-1:0]   file_length,
	input  logic [pfsm_pkg::W_PNUM-1:0]   piece_number,
	input  logic [pfsm_pkg::W_BYTES-1:0]  byte_count,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfsm_pkg::W_STAT-1:0]   status,
	output logic [pfsm_pkg::W_IDX-1:0]    entry_index,
	output logic [pfsm_pkg::W_FLEN-1:0]   offset_in_file,
	output logic [pfsm_pkg::W_BYTES-1:0]  segment_length,
	output logic [pfsm_pkg::W_BYTES-1:0]  position_in_piece,
	output logic                          last
);

	localparam int AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;  // table address
	localparam int CW = $clog2(MAX_FILES + 1);                    // count / walk index
	localparam int RW = pfsm_pkg::W_START + pfsm_pkg::W_FLEN;     // table word

	// ---------------- sequencer ----------------
	logic [pfsm_pkg::PC_W-1:0] pc_q;
	pfsm_pkg::ctl_t            ctl;
	logic                      hold_act;
	logic                      jump_act;
	logic                      fire;

	// ---------------- state ----------------
	logic [pfsm_pkg::W_BYTES-1:0] piece_size_q;
	logic [CW-1:0]                count_q;
	logic [pfsm_pkg::W_START-1:0] run_q;

	// latched input transaction
	logic [pfsm_pkg::W_CMD-1:0]   cmd_q;
	logic [pfsm_pkg::W_FLEN-1:0]  flen_q;
	logic [pfsm_pkg::W_PNUM-1:0]  pnum_q;
	logic [pfsm_pkg::W_BYTES-1:0] bcnt_q;

	// walk datapath
	logic [CW-1:0]                idx_q;
	logic [pfsm_pkg::W_POFF-1:0]  poff_q;    // global offset of the unplaced bytes
	logic [pfsm_pkg::W_BYTES-1:0] left_q;    // bytes still to place
	logic [pfsm_pkg::W_BYTES-1:0] pos_q;     // position in piece of unplaced bytes
	logic [pfsm_pkg::W_START-1:0] fs_q;      // entry start
	logic [pfsm_pkg::W_FLEN-1:0]  fl_q;      // entry length
	logic [pfsm_pkg::W_END-1:0]   fend_q;    // entry end
	logic [pfsm_pkg::W_POFF-1:0]  rend_q;    // range end
	logic                         ovl_q;
	logic [pfsm_pkg::W_POFF-1:0]  s_q;       // segment start within file
	logic [pfsm_pkg::W_POFF-1:0]  eraw_q;    // range end relative to file start
	logic [pfsm_pkg::W_BYTES-1:0] w_q;       // segment width

	// held segment: flushed with last=0 when a further one turns up
	logic                         held_q;
	logic [pfsm_pkg::W_IDX-1:0]   h_idx_q;
	logic [pfsm_pkg::W_FLEN-1:0]  h_off_q;
	logic [pfsm_pkg::W_BYTES-1:0] h_len_q;
	logic [pfsm_pkg::W_BYTES-1:0] h_pos_q;

	// output register
	logic                         out_valid_q;
	logic                         out_free;
	logic                         out_load;
	logic [pfsm_pkg::W_STAT-1:0]  o_stat_d,  o_stat_q;
	logic [pfsm_pkg::W_IDX-1:0]   o_idx_d,   o_idx_q;
	logic [pfsm_pkg::W_FLEN-1:0]  o_off_d,   o_off_q;
	logic [pfsm_pkg::W_BYTES-1:0] o_len_d,   o_len_q;
	logic [pfsm_pkg::W_BYTES-1:0] o_pos_d,   o_pos_q;
	logic                         o_last_d,  o_last_q;

	// table RAM
	logic          tbl_we;
	logic [RW-1:0] tbl_rdata;

	logic                         in_take;
	logic                         tbl_full;
	logic                         is_append;
	logic [pfsm_pkg::W_END-1:0]   run_sum;
	logic [pfsm_pkg::W_FLEN-1:0]  e_clip;

	assign ctl      = pfsm_pkg::ucode(pc_q);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (ctl.op != pfsm_pkg::OP_ACCEPT);
	assign in_take  = in_valid && !in_stall;

	assign tbl_full  = (count_q >= CW'(MAX_FILES));
	assign is_append = (cmd_q == pfsm_pkg::CMD_APPEND);
	assign run_sum   = pfsm_pkg::W_END'(run_q) + pfsm_pkg::W_END'(flen_q);

	always_comb begin
		case (ctl.hold)
			pfsm_pkg::H_NONE:   hold_act = 1'b0;
			pfsm_pkg::H_IN:     hold_act = !in_valid;
			pfsm_pkg::H_HELD:   hold_act = held_q && !out_free;
			pfsm_pkg::H_OUT:    hold_act = !out_free;
			pfsm_pkg::H_APPEND: hold_act = is_append && !out_free;
			default:            hold_act = 1'b0;
		endcase
	end

	always_comb begin
		case (ctl.cond)
			pfsm_pkg::C_NEVER:     jump_act = 1'b0;
			pfsm_pkg::C_ALWAYS:    jump_act = 1'b1;
			pfsm_pkg::C_NOT_MAP:   jump_act = (cmd_q != pfsm_pkg::CMD_MAP);
			pfsm_pkg::C_WALK_DONE: jump_act = (idx_q >= count_q) || (left_q == '0);
			pfsm_pkg::C_NO_OVL:    jump_act = !ovl_q;
			default:               jump_act = 1'b0;
		endcase
	end

	assign fire = !hold_act;

	// Output load selection: flush of a held segment, final map result, append answer.
	always_comb begin
		out_load = 1'b0;
		o_stat_d = pfsm_pkg::ST_SEGMENT;
		o_idx_d  = h_idx_q;
		o_off_d  = h_off_q;
		o_len_d  = h_len_q;
		o_pos_d  = h_pos_q;
		o_last_d = 1'b0;
		if (fire) begin
			case (ctl.op)
				pfsm_pkg::OP_EMIT: begin
					out_load = held_q;
				end
				pfsm_pkg::OP_MFIN: begin
					out_load = 1'b1;
					o_last_d = 1'b1;
					if (!held_q) begin
						o_stat_d = pfsm_pkg::ST_NO_OVL;
						o_idx_d  = '0;
						o_off_d  = '0;
						o_len_d  = '0;
						o_pos_d  = '0;
					end
				end
				pfsm_pkg::OP_CMD: begin
					out_load = is_append;
					o_last_d = 1'b1;
					o_stat_d = tbl_full ? pfsm_pkg::ST_FULL : pfsm_pkg::ST_APP_OK;
					o_idx_d  = tbl_full ? '0 : pfsm_pkg::W_IDX'(count_q);
					o_off_d  = '0;
					o_len_d  = '0;
					o_pos_d  = '0;
				end
				default: begin
					out_load = 1'b0;
				end
			endcase
		end
	end

	assign tbl_we = fire && (ctl.op == pfsm_pkg::OP_CMD) && is_append && !tbl_full;

	pfsm_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_FILES)
	) u_tbl (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({run_q, flen_q}),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (tbl_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= pfsm_pkg::PC_ACCEPT;
			piece_size_q <= pfsm_pkg::PIECE_SIZE_RST;
			count_q      <= '0;
			run_q        <= '0;
			held_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				piece_size_q <= cfg_wr_data;
			end

			if (hold_act) begin
				pc_q <= pc_q;
			end else if (jump_act) begin
				pc_q <= ctl.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (fire) begin
				case (ctl.op)
					pfsm_pkg::OP_MUL:  held_q <= 1'b0;
					pfsm_pkg::OP_EMIT: held_q <= 1'b1;
					pfsm_pkg::OP_CMD: begin
						if (cmd_q == pfsm_pkg::CMD_CLEAR) begin
							count_q <= '0;
							run_q   <= '0;
						end else if (is_append && !tbl_full) begin
							count_q <= count_q + 1'b1;
							// saturate the running start offset
							run_q   <= run_sum[pfsm_pkg::W_START] ? '1
							           : run_sum[pfsm_pkg::W_START-1:0];
						end
					end
					default: begin
						held_q <= held_q;
					end
				endcase
			end
		end
	end

	assign e_clip = (eraw_q > pfsm_pkg::W_POFF'(fl_q)) ? fl_q : eraw_q[pfsm_pkg::W_FLEN-1:0];

	// Datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q  <= cmd;
			flen_q <= file_length;
			pnum_q <= piece_number;
			bcnt_q <= byte_count;
		end

		if (out_load) begin
			o_stat_q <= o_stat_d;
			o_idx_q  <= o_idx_d;
			o_off_q  <= o_off_d;
			o_len_q  <= o_len_d;
			o_pos_q  <= o_pos_d;
			o_last_q <= o_last_d;
		end

		if (fire) begin
			case (ctl.op)
				pfsm_pkg::OP_MUL: begin
					poff_q <= pfsm_pkg::W_POFF'(pfsm_pkg::W_PROD'(pnum_q)
					          * pfsm_pkg::W_PROD'(piece_size_q));
					left_q <= bcnt_q;
					pos_q  <= '0;
					idx_q  <= '0;
				end
				pfsm_pkg::OP_LD: begin
					fs_q   <= tbl_rdata[RW-1:pfsm_pkg::W_FLEN];
					fl_q   <= tbl_rdata[pfsm_pkg::W_FLEN-1:0];
					fend_q <= pfsm_pkg::W_END'(tbl_rdata[RW-1:pfsm_pkg::W_FLEN])
					          + pfsm_pkg::W_END'(tbl_rdata[pfsm_pkg::W_FLEN-1:0]);
					rend_q <= poff_q + pfsm_pkg::W_POFF'(left_q);
				end
				pfsm_pkg::OP_CHK: begin
					ovl_q  <= (poff_q < pfsm_pkg::W_POFF'(fend_q))
					          && (rend_q > pfsm_pkg::W_POFF'(fs_q));
					s_q    <= (poff_q > pfsm_pkg::W_POFF'(fs_q))
					          ? poff_q - pfsm_pkg::W_POFF'(fs_q) : '0;
					eraw_q <= rend_q - pfsm_pkg::W_POFF'(fs_q);
				end
				pfsm_pkg::OP_CALC: begin
					// on overlap the width never exceeds the bytes left
					w_q <= pfsm_pkg::W_BYTES'(e_clip - s_q[pfsm_pkg::W_FLEN-1:0]);
				end
				pfsm_pkg::OP_EMIT: begin
					h_idx_q <= pfsm_pkg::W_IDX'(idx_q);
					h_off_q <= s_q[pfsm_pkg::W_FLEN-1:0];
					h_len_q <= w_q;
					h_pos_q <= pos_q;
					pos_q   <= pos_q + w_q;
					left_q  <= left_q - w_q;
					poff_q  <= poff_q + pfsm_pkg::W_POFF'(w_q);
				end
				pfsm_pkg::OP_NEXT: begin
					idx_q <= idx_q + 1'b1;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = o_stat_q;
	assign entry_index       = o_idx_q;
	assign offset_in_file    = o_off_q;
	assign segment_length    = o_len_q;
	assign position_in_piece = o_pos_q;
	assign last              = o_last_q;

endmodule
